// ===== hdl/acss_pkg.sv =====
// Shared types and constants for the axis calibrate/smooth/scale block.
// Used by acss_sdiv and axis_calibrate_smooth_scale; depends on nothing.
package acss_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int DZ_W        = 15;
	localparam int TRIM_W      = 4;
	localparam int WIN_W       = 5;
	localparam int EDGE_W      = 18;
	localparam int DIV_W       = 16;
	localparam int DVD_W       = 32;
	localparam int DCNT_W      = 5;
	localparam int AVG_QBITS   = 16;
	localparam int SCALE_QBITS = 15;

	localparam logic signed [SAMPLE_W-1:0] FULL_POS   = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] FULL_NEG   = -16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] LIMIT_LOW_RST  = -16'sd32768;
	localparam logic signed [SAMPLE_W-1:0] LIMIT_HIGH_RST = 16'sd32767;
	localparam logic [WIN_W-1:0]           WINDOW_RST = 5'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_LOW     = 3'd0,
		REG_LIMIT_HIGH    = 3'd1,
		REG_CENTER_POINT  = 3'd2,
		REG_DEAD_ZONE     = 3'd3,
		REG_AUTO_LIMIT    = 3'd4,
		REG_AUTO_CENTER   = 3'd5,
		REG_TRIM_BITS     = 3'd6,
		REG_SMOOTH_WINDOW = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		DIV_AVG,
		DIV_SCALE
	} div_op_t;

	typedef struct packed {
		logic              start;
		div_op_t           op;
		logic [DVD_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_W-1:0]  quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HIST,
		S_AVG_START,
		S_AVG_RUN,
		S_TRIM,
		S_MAP,
		S_SCALE_START,
		S_SCALE_RUN,
		S_DONE
	} state_t;

endpackage

// ===== hdl/acss_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on acss_pkg for the request/response structs and quotient lengths.
module acss_sdiv import acss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dq_q;
	logic [DIV_W-1:0]  div_q;

	logic [DIV_W:0]    part;
	logic [DIV_W:0]    diff;
	logic              ge;
	logic [DIV_W-1:0]  rem_init;
	logic [DVD_W-1:0]  dq_init;
	logic [DCNT_W-1:0] cnt_init;

	always_comb begin
		part = {rem_q, dq_q[DVD_W-1]};
		diff = part - {1'b0, div_q};
		ge   = part >= {1'b0, div_q};
	end

	// align so the upper part is below the divisor and only the wanted bits remain
	always_comb begin
		unique case (req.op)
			DIV_AVG: begin
				rem_init = DIV_W'(req.dividend >> AVG_QBITS);
				dq_init  = req.dividend << (DVD_W - AVG_QBITS);
				cnt_init = DCNT_W'(AVG_QBITS);
			end
			DIV_SCALE: begin
				rem_init = DIV_W'(req.dividend >> SCALE_QBITS);
				dq_init  = req.dividend << (DVD_W - SCALE_QBITS);
				cnt_init = DCNT_W'(SCALE_QBITS);
			end
			default: begin
				rem_init = '0;
				dq_init  = '0;
				cnt_init = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cnt_init;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem_init;
			dq_q  <= dq_init;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : part[DIV_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = busy_q && (cnt_q == DCNT_W'(1));
	assign rsp.quotient = dq_q[DIV_W-1:0];

endmodule

// ===== hdl/axis_calibrate_smooth_scale.sv =====
// Axis calibrator top level: limit tracking, moving average, trim, dead zone scaling.
// Depends on acss_pkg and instantiates the serial divider acss_sdiv.
//
// channel | signals                                          | dir | taken when
// config  | cfg_we, cfg_index, cfg_data                      | in  | cfg_we high
// sample  | sample_valid, sample_ready, raw_sample           | in  | valid and ready
// result  | result_valid, result_ready, axis_out, smoothed_position | out | valid and ready
//
// One item at a time: a new sample is taken only once the last result is loaded;
// zero or saturated results skip the range-scaling division. The one-bit-per-cycle
// divider computes 16 bits for the rounded average, 15 for the range scaling.
// Reset clears all control state at once; there is no clearing pass.
// The result register holds a stalled item; the next sample is taken meanwhile.
module axis_calibrate_smooth_scale import acss_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] raw_sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [SAMPLE_W-1:0] axis_out,
	output logic signed [SAMPLE_W-1:0] smoothed_position
);

	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;

	state_t state_q, state_nx;

	// configuration and control state
	logic signed [SAMPLE_W-1:0] tl_q, th_q, center_q;
	logic [DZ_W-1:0]            dz_q;
	logic                       auto_limit_q, first_seen_q, locked_q;
	logic [TRIM_W-1:0]          trim_q;
	logic [WIN_W-1:0]           window_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic [PTR_W-1:0]           rp_q;
	logic                       result_valid_q;

	// payload
	logic signed [SAMPLE_W-1:0] ring_q [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] raw_q, v_q, res_q, axis_q, pos_q;
	logic signed [EDGE_W-1:0]   edge_n_q, edge_p_q;
	logic                       below_q, zero_q, den_ok_q, from_div_q;
	logic [DIV_W-1:0]           d_q, den_q;

	logic                       accept, out_load, sat;
	logic [CNT_W-1:0]           win_len;
	logic signed [SAMPLE_W-1:0] v_cl, ring_old;
	logic                       full;
	logic signed [SUM_W-1:0]    sum_nx;
	logic [SUM_W-1:0]           sum_mag;
	logic [DVD_W-1:0]           avg_dividend, num;
	logic signed [EDGE_W-1:0]   dz_ext, edge_n, edge_p, mid_ext, v_ext;
	logic signed [SAMPLE_W:0]   lim_sum, mid;
	logic                       lock_now;
	logic [DIV_W-1:0]           mag_t;
	logic [SAMPLE_W:0]          v_signed;
	logic signed [EDGE_W:0]     d_w, den_w;
	logic                       below, above;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	acss_sdiv u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (window_q == '0) begin
			win_len = CNT_W'(1);
		end else if (32'(window_q) > MAX_WINDOW) begin
			win_len = CNT_W'(MAX_WINDOW);
		end else begin
			win_len = CNT_W'(window_q);
		end
	end

	// clamp and history
	always_comb begin
		priority if (raw_q < tl_q) begin
			v_cl = tl_q;
		end else if (raw_q > th_q) begin
			v_cl = th_q;
		end else begin
			v_cl = raw_q;
		end
		full     = count_q >= win_len;
		ring_old = full ? ring_q[rp_q] : '0;
		sum_nx   = sum_q + SUM_W'(v_cl) - SUM_W'(ring_old);
	end

	// dead zone edges and lock
	always_comb begin
		dz_ext   = $signed(EDGE_W'(dz_q));
		edge_n   = EDGE_W'(center_q) - dz_ext;
		edge_p   = EDGE_W'(center_q) + dz_ext;
		lim_sum  = (SAMPLE_W+1)'(tl_q) + (SAMPLE_W+1)'(th_q);
		mid      = lim_sum >>> 1;
		mid_ext  = EDGE_W'(mid);
		lock_now = locked_q || (edge_n < EDGE_W'(tl_q)) || (edge_p > EDGE_W'(th_q));
	end

	// rounded average setup and trim
	always_comb begin
		sum_mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		avg_dividend = (DVD_W'(sum_mag) << 1) + DVD_W'(count_q);
		mag_t        = div_rsp.quotient & ({DIV_W{1'b1}} << trim_q);
		v_signed     = sum_q[SUM_W-1] ? -{1'b0, mag_t} : {1'b0, mag_t};
	end

	// mapping around the edges
	always_comb begin
		v_ext = EDGE_W'(v_q);
		below = v_ext < edge_n_q;
		above = v_ext > edge_p_q;
		if (below) begin
			d_w   = (EDGE_W+1)'(edge_n_q) - (EDGE_W+1)'(v_ext);
			den_w = (EDGE_W+1)'(edge_n_q) - (EDGE_W+1)'(tl_q);
		end else begin
			d_w   = (EDGE_W+1)'(v_ext) - (EDGE_W+1)'(edge_p_q);
			den_w = (EDGE_W+1)'(th_q) - (EDGE_W+1)'(edge_p_q);
		end
		num = (DVD_W'(d_q) << SCALE_QBITS) - DVD_W'(d_q);
		sat = !den_ok_q || ((num >> SCALE_QBITS) >= DVD_W'(den_q));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:        if (sample_valid) state_nx = S_HIST;
			S_HIST:        state_nx = S_AVG_START;
			S_AVG_START:   state_nx = S_AVG_RUN;
			S_AVG_RUN:     if (div_rsp.done) state_nx = S_TRIM;
			S_TRIM:        state_nx = S_MAP;
			S_MAP:         state_nx = S_SCALE_START;
			S_SCALE_START: state_nx = (zero_q || sat) ? S_DONE : S_SCALE_RUN;
			S_SCALE_RUN:   if (div_rsp.done) state_nx = S_DONE;
			S_DONE:        if (!result_valid_q || result_ready) state_nx = S_IDLE;
			default:       state_nx = S_IDLE;
		endcase
	end

	// state decode
	always_comb begin
		sample_ready     = state_q == S_IDLE;
		accept           = sample_valid && sample_ready;
		out_load         = (state_q == S_DONE) && (!result_valid_q || result_ready);
		div_req.start    = (state_q == S_AVG_START) ||
		                   ((state_q == S_SCALE_START) && !zero_q && !sat);
		div_req.op       = (state_q == S_SCALE_START) ? DIV_SCALE : DIV_AVG;
		div_req.dividend = (state_q == S_SCALE_START) ? num : avg_dividend;
		div_req.divisor  = (state_q == S_SCALE_START) ? den_q
		                                              : DIV_W'({count_q, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			tl_q           <= LIMIT_LOW_RST;
			th_q           <= LIMIT_HIGH_RST;
			center_q       <= '0;
			dz_q           <= '0;
			auto_limit_q   <= 1'b0;
			first_seen_q   <= 1'b0;
			locked_q       <= 1'b1;
			trim_q         <= '0;
			window_q       <= WINDOW_RST;
			sum_q          <= '0;
			count_q        <= '0;
			rp_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_LIMIT_LOW: begin
						tl_q         <= $signed(cfg_data);
						auto_limit_q <= 1'b0;
					end
					REG_LIMIT_HIGH: begin
						th_q         <= $signed(cfg_data);
						auto_limit_q <= 1'b0;
					end
					REG_CENTER_POINT: begin
						center_q <= $signed(cfg_data);
						locked_q <= 1'b0;
					end
					REG_DEAD_ZONE: begin
						dz_q     <= cfg_data[DZ_W-1:0];
						locked_q <= 1'b0;
					end
					REG_AUTO_LIMIT: begin
						auto_limit_q <= cfg_data[0];
						if (cfg_data[0]) begin
							first_seen_q <= 1'b0;
						end
					end
					REG_AUTO_CENTER: locked_q <= cfg_data[0];
					REG_TRIM_BITS:   trim_q <= cfg_data[TRIM_W-1:0];
					REG_SMOOTH_WINDOW: begin
						window_q <= cfg_data[WIN_W-1:0];
						sum_q    <= '0;
						count_q  <= '0;
						rp_q     <= '0;
					end
					default: ;
				endcase
			end else if (accept) begin
				if (auto_limit_q) begin
					if (!first_seen_q) begin
						tl_q         <= raw_sample;
						th_q         <= raw_sample;
						first_seen_q <= 1'b1;
					end else begin
						if (raw_sample < tl_q) tl_q <= raw_sample;
						if (raw_sample > th_q) th_q <= raw_sample;
					end
				end
			end else if (state_q == S_HIST) begin
				sum_q    <= sum_nx;
				locked_q <= lock_now;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
				if (32'(rp_q) + 1 == 32'(win_len)) begin
					rp_q <= '0;
				end else begin
					rp_q <= rp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HIST) begin
			ring_q[rp_q] <= v_cl;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= raw_sample;
		end
		if (state_q == S_HIST) begin
			edge_n_q <= lock_now ? mid_ext : edge_n;
			edge_p_q <= lock_now ? mid_ext : edge_p;
		end
		if (state_q == S_TRIM) begin
			v_q <= v_signed[SAMPLE_W-1:0];
		end
		if (state_q == S_MAP) begin
			below_q  <= below;
			zero_q   <= !below && !above;
			d_q      <= d_w[DIV_W-1:0];
			den_q    <= den_w[DIV_W-1:0];
			den_ok_q <= den_w > 0;
		end
		if (state_q == S_SCALE_START) begin
			from_div_q <= !zero_q && !sat;
			if (zero_q) begin
				res_q <= '0;
			end else begin
				res_q <= below_q ? FULL_NEG : FULL_POS;
			end
		end
		if (out_load) begin
			pos_q <= v_q;
			if (from_div_q) begin
				axis_q <= below_q ? $signed(~div_rsp.quotient + 1'b1)
				                  : $signed(div_rsp.quotient);
			end else begin
				axis_q <= res_q;
			end
		end
	end

	assign result_valid      = result_valid_q;
	assign axis_out          = axis_q;
	assign smoothed_position = pos_q;

endmodule
